>>> src/pgmap_pkg.sv
// pgmap_pkg: shared types, widths and codes of the four-level page table mapper
`default_nettype none

package pgmap_pkg;

    localparam int PGMAP_FRAMES = 64;
    localparam int ENTRIES      = 512;
    localparam int IDX_W        = 9;
    localparam int ENTRY_W      = 64;
    localparam int VA_W         = 48;
    localparam int PA_W         = 52;
    localparam int BASE_W       = 40;
    localparam int PAGE_SHIFT   = 12;
    localparam int STATUS_W     = 2;
    localparam int CREATED_W    = 2;

    typedef enum logic {
        OP_MAP   = 1'b0,
        OP_UNMAP = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_FRAME = 2'd1,
        STAT_OUTSIDE  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        LVL_4 = 2'd0,
        LVL_3 = 2'd1,
        LVL_2 = 2'd2,
        LVL_1 = 2'd3
    } t_level;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_LEAF,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

>>> src/pgmap_req_if.sv
// pgmap_req_if: request channel carrying one map or unmap item
`default_nettype none

interface pgmap_req_if
    import pgmap_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [VA_W-1:0]    virt_addr;
    logic [PA_W-1:0]    page_addr;
    logic [ENTRY_W-1:0] flags;

    modport source (output valid, output opcode, output virt_addr, output page_addr,
                    output flags, input ready);
    modport sink   (input valid, input opcode, input virt_addr, input page_addr,
                    input flags, output ready);
endinterface

`default_nettype wire

>>> src/pgmap_rsp_if.sv
// pgmap_rsp_if: result channel carrying one result item per request
`default_nettype none

interface pgmap_rsp_if
    import pgmap_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [ENTRY_W-1:0]   entry_value;
    logic [CREATED_W-1:0] tables_created;
    logic [VA_W-1:0]      invalidate_addr;

    modport source (output valid, output status, output entry_value, output tables_created,
                    output invalidate_addr, input ready);
    modport sink   (input valid, input status, input entry_value, input tables_created,
                    input invalidate_addr, output ready);
endinterface

`default_nettype wire

>>> src/pgmap_ram.sv
// pgmap_ram: generic single-write, single-read ram with registered read data
`default_nettype none

module pgmap_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> src/four_level_page_table_mapper.sv
// four_level_page_table_mapper: walks and updates a four-level page table kept in one ram
//
//   channel   dir  handshake          payload
//   i_req     in   valid/ready        opcode, virt_addr, page_addr, flags
//   o_rsp     out  valid/ready        status, entry_value, tables_created, invalidate_addr
//   cfg       in   i_cfg_we           i_cfg_wdata (table_base_frame)
//
// each level takes S_READ (address) then S_EVAL (registered ram data); a full map
// walk ends with the leaf write in S_LEAF and S_DONE, one item at a time.
// walks that stop early (unmap of absent level, bad link, no frames) finish sooner.
// after reset a clearing pass writes FRAMES*512 entries, one per cycle, before the
// first item is taken. a stalled result holds in the output register while the
// next item is accepted and walked.
`default_nettype none

module four_level_page_table_mapper
    import pgmap_pkg::*;
#(
    parameter int FRAMES = PGMAP_FRAMES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [BASE_W-1:0] i_cfg_wdata,
    pgmap_req_if.sink              i_req,
    pgmap_rsp_if.source            o_rsp
);

    localparam int DEPTH = FRAMES * ENTRIES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(FRAMES);
    localparam int NW    = $clog2(FRAMES + 1);

    t_state               r_state, n_state;
    logic [AW-1:0]        r_clr, n_clr;
    logic [BASE_W-1:0]    r_base, n_base;
    logic [NW-1:0]        r_nff, n_nff;
    logic [CW-1:0]        r_cur, n_cur;
    t_level               r_lvl, n_lvl;
    logic                 r_op, n_op;
    logic [VA_W-1:0]      r_va, n_va;
    logic [PA_W-1:0]      r_pp, n_pp;
    logic [ENTRY_W-1:0]   r_flags, n_flags;
    t_status              r_status, n_status;
    logic [ENTRY_W-1:0]   r_value, n_value;
    logic [CREATED_W-1:0] r_created, n_created;
    logic                 r_out_valid, n_out_valid;
    t_status              r_out_status, n_out_status;
    logic [ENTRY_W-1:0]   r_out_value, n_out_value;
    logic [CREATED_W-1:0] r_out_created, n_out_created;
    logic [VA_W-1:0]      r_out_inval, n_out_inval;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [AW-1:0]        slot;
    logic [IDX_W-1:0]     idx;
    logic [BASE_W:0]      link_diff;
    logic                 present;
    logic                 link_ok;
    logic                 frames_out;
    logic [BASE_W-1:0]    new_pfn;
    logic [ENTRY_W-1:0]   new_entry;
    logic [ENTRY_W-1:0]   leaf_value;
    t_level               lvl_inc;

    pgmap_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (slot),
        .o_rdata (ram_rdata)
    );

    // 9-bit index of the current level
    always_comb begin
        case (r_lvl)
            LVL_4:   idx = r_va[47:39];
            LVL_3:   idx = r_va[38:30];
            LVL_2:   idx = r_va[29:21];
            default: idx = r_va[20:12];
        endcase
    end

    always_comb begin
        case (r_lvl)
            LVL_4:   lvl_inc = LVL_3;
            LVL_3:   lvl_inc = LVL_2;
            default: lvl_inc = LVL_1;
        endcase
    end

    assign slot       = {r_cur, idx};
    assign present    = ram_rdata[0];
    // link target must be an allocated frame of the store
    assign link_diff  = {1'b0, ram_rdata[PA_W-1:PAGE_SHIFT]} - {1'b0, r_base};
    assign link_ok    = !link_diff[BASE_W] && (link_diff[BASE_W-1:0] < BASE_W'(r_nff));
    assign frames_out = (r_nff == NW'(FRAMES));
    assign new_pfn    = r_base + BASE_W'(r_nff);
    assign new_entry  = {{(ENTRY_W - PA_W){1'b0}}, new_pfn, {PAGE_SHIFT{1'b0}}} | r_flags;
    assign leaf_value = (r_op == OP_UNMAP) ? '0
                      : ({{(ENTRY_W - PA_W){1'b0}}, r_pp} | r_flags);

    assign i_req.ready           = (r_state == S_IDLE);
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.entry_value     = r_out_value;
    assign o_rsp.tables_created  = r_out_created;
    assign o_rsp.invalidate_addr = r_out_inval;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (present) begin
                    if (!link_ok) begin
                        n_state = S_DONE;
                    end else if (r_lvl == LVL_2) begin
                        n_state = S_LEAF;
                    end else begin
                        n_state = S_READ;
                    end
                end else if (r_op == OP_UNMAP || frames_out) begin
                    n_state = S_DONE;
                end else if (r_lvl == LVL_2) begin
                    n_state = S_LEAF;
                end else begin
                    n_state = S_READ;
                end
            end
            S_LEAF: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and ram control
    always_comb begin
        n_clr         = r_clr;
        n_base        = i_cfg_we ? i_cfg_wdata : r_base;
        n_nff         = r_nff;
        n_cur         = r_cur;
        n_lvl         = r_lvl;
        n_op          = r_op;
        n_va          = r_va;
        n_pp          = r_pp;
        n_flags       = r_flags;
        n_status      = r_status;
        n_value       = r_value;
        n_created     = r_created;
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_out_status  = r_out_status;
        n_out_value   = r_out_value;
        n_out_created = r_out_created;
        n_out_inval   = r_out_inval;
        ram_we        = 1'b0;
        ram_waddr     = slot;
        ram_wdata     = '0;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = AW'(r_clr + 1'b1);
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op      = i_req.opcode;
                    n_va      = i_req.virt_addr;
                    n_pp      = i_req.page_addr;
                    n_flags   = i_req.flags;
                    n_cur     = '0;
                    n_lvl     = LVL_4;
                    n_status  = STAT_OK;
                    n_value   = '0;
                    n_created = '0;
                end
            end
            S_EVAL: begin
                if (present) begin
                    if (link_ok) begin
                        n_cur = link_diff[CW-1:0];
                        n_lvl = lvl_inc;
                    end else begin
                        n_status = STAT_OUTSIDE;
                    end
                end else if (r_op == OP_UNMAP) begin
                    n_status = STAT_OK;
                end else if (frames_out) begin
                    n_status = STAT_NO_FRAME;
                end else begin
                    // link a fresh frame; it is still all zero from the clearing pass
                    ram_we    = 1'b1;
                    ram_wdata = new_entry;
                    n_cur     = r_nff[CW-1:0];
                    n_nff     = NW'(r_nff + 1'b1);
                    n_created = CREATED_W'(r_created + 1'b1);
                    n_lvl     = lvl_inc;
                end
            end
            S_LEAF: begin
                ram_we    = 1'b1;
                ram_wdata = leaf_value;
                n_value   = leaf_value;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_status;
                    n_out_value   = r_value;
                    n_out_created = r_created;
                    n_out_inval   = (r_status == STAT_OK)
                                  ? {r_va[VA_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}} : '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_base      <= '0;
            r_nff       <= NW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_base      <= n_base;
            r_nff       <= n_nff;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur         <= n_cur;
        r_lvl         <= n_lvl;
        r_op          <= n_op;
        r_va          <= n_va;
        r_pp          <= n_pp;
        r_flags       <= n_flags;
        r_status      <= n_status;
        r_value       <= n_value;
        r_created     <= n_created;
        r_out_status  <= n_out_status;
        r_out_value   <= n_out_value;
        r_out_created <= n_out_created;
        r_out_inval   <= n_out_inval;
    end

`ifndef SYNTHESIS
    a_nff_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nff != '0) && (r_nff <= NW'(FRAMES)))
        else $error("free frame counter out of range");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_req.ready)
        else $error("item accepted during clearing pass");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_CLEAR || r_state == S_EVAL || r_state == S_LEAF))
        else $error("table write outside a writing state");

    a_alloc_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && ram_we) |=> (r_nff == NW'($past(r_nff) + 1'b1)))
        else $error("level created without frame allocation");

    a_fail_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != STAT_OK)
            |-> (o_rsp.entry_value == '0 && o_rsp.invalidate_addr == '0))
        else $error("failed item reports a written value or invalidation");
`endif

endmodule

`default_nettype wire

>>> sim/four_level_page_table_mapper_tb.sv
// four_level_page_table_mapper_tb: map/unmap walks against a shadow page table, result checking
`default_nettype none

module four_level_page_table_mapper_tb
    import pgmap_pkg::*;
();

    localparam int STORE_DEPTH     = PGMAP_FRAMES * ENTRIES;
    // the clearing pass after reset alone writes FRAMES*512 entries
    localparam int WATCHDOG_LIMIT  = 100000;
    localparam int RSP_HOLD_CYCLES = 400;
    localparam int WALK_SETTLE     = 12;

    localparam logic [ENTRY_W-1:0] FL_PRESENT = 64'h1;
    localparam logic [ENTRY_W-1:0] FL_RW      = 64'h2;
    localparam logic [ENTRY_W-1:0] FL_NX      = 64'h8000_0000_0000_0000;
    // low-bit and high-bit flag fields only, address bits 12..51 kept clear
    localparam logic [ENTRY_W-1:0] FL_FIELDS  = 64'hFFF0_0000_0000_0FFF;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [ENTRY_W-1:0]   entry_value;
        logic [CREATED_W-1:0] tables_created;
        logic [VA_W-1:0]      invalidate_addr;
    } t_walk_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [BASE_W-1:0] i_cfg_wdata;

    pgmap_req_if req_ch ();
    pgmap_rsp_if rsp_ch ();

    four_level_page_table_mapper #(
        .FRAMES (PGMAP_FRAMES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow copy of the table store and allocator
    logic [ENTRY_W-1:0] shadow_tables [STORE_DEPTH];
    int unsigned        next_frame;
    logic [BASE_W-1:0]  table_base;

    t_walk_result results_due [$];

    bit failed        = 1'b0;
    bit gaps_on       = 1'b1;
    bit rsp_hold_req  = 1'b0;
    int items_sent    = 0;
    int n_ok          = 0;
    int n_no_frame    = 0;
    int n_outside     = 0;
    int n_created     = 0;
    int idle_cycles   = 0;

    function automatic t_walk_result predict_walk(input t_opcode op, input logic [VA_W-1:0] va,
                                                  input logic [PA_W-1:0] pp,
                                                  input logic [ENTRY_W-1:0] fl);
        t_walk_result      r;
        int unsigned       cur;
        int unsigned       slot;
        logic [ENTRY_W-1:0] e;
        logic [BASE_W-1:0] pfn;
        logic [BASE_W-1:0] link_off;
        logic [BASE_W-1:0] new_pfn;
        bit                absent;
        r      = '0;
        cur    = 0;
        absent = 1'b0;
        for (int lv = 0; lv < 3; lv++) begin
            slot = cur * ENTRIES + va[VA_W-1-IDX_W*lv -: IDX_W];
            e    = shadow_tables[slot];
            if (e[0]) begin
                pfn      = e[PA_W-1:PAGE_SHIFT];
                link_off = pfn - table_base;
                if (pfn < table_base || link_off >= BASE_W'(next_frame)) begin
                    r.status = STAT_OUTSIDE;
                    break;
                end
                cur = 32'(link_off);
            end else if (op == OP_UNMAP) begin
                absent = 1'b1;
                break;
            end else if (next_frame >= PGMAP_FRAMES) begin
                r.status = STAT_NO_FRAME;
                break;
            end else begin
                new_pfn = table_base + BASE_W'(next_frame);
                shadow_tables[slot] = {12'b0, new_pfn, 12'b0} | fl;
                cur = next_frame;
                next_frame++;
                r.tables_created++;
            end
        end
        if (r.status == STAT_OK && !absent) begin
            r.entry_value = (op == OP_UNMAP) ? '0 : ({12'b0, pp} | fl);
            shadow_tables[cur * ENTRIES + va[20:12]] = r.entry_value;
        end
        if (r.status == STAT_OK)
            r.invalidate_addr = {va[VA_W-1:PAGE_SHIFT], 12'b0};
        return r;
    endfunction

    function automatic logic [VA_W-1:0] make_va(input logic [IDX_W-1:0] l4, l3, l2, l1,
                                                input logic [11:0] offset);
        return {l4, l3, l2, l1, offset};
    endfunction

    function automatic logic [PA_W-1:0] rand_page();
        return {20'($urandom), 32'($urandom)};
    endfunction

    // sane entry flags: present most of the time, address field clear
    function automatic logic [ENTRY_W-1:0] entry_flags();
        logic [ENTRY_W-1:0] f;
        f    = {$urandom, $urandom} & FL_FIELDS;
        f[0] = ($urandom_range(0, 99) < 97);
        return f;
    endfunction

    function automatic int pause_cycles();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(input t_opcode op, input logic [VA_W-1:0] va,
                                input logic [PA_W-1:0] pp, input logic [ENTRY_W-1:0] fl,
                                output t_walk_result res);
        int gap;
        gap = pause_cycles();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        res = predict_walk(op, va, pp, fl);
        results_due.push_back(res);
        items_sent++;
        req_ch.valid     <= 1'b1;
        req_ch.opcode    <= op;
        req_ch.virt_addr <= va;
        req_ch.page_addr <= pp;
        req_ch.flags     <= fl;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic load_table_base(input logic [BASE_W-1:0] base);
        req_ch.valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (WALK_SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= base;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        table_base = base;
    endtask

    // mostly walks through a few shared prefixes so tables get reused
    task automatic run_random(input int count, input logic [4*IDX_W-1:0] l4_set,
                              input int l3_n, input int l2_n, input int hold_at);
        t_walk_result       r;
        logic [VA_W-1:0]    va;
        logic [VA_W-1:0]    path_va;
        logic [ENTRY_W-1:0] fl;
        logic [IDX_W-1:0]   l1;
        bit                 have_path;
        int                 pick;
        int                 k;
        have_path = 1'b0;
        path_va   = '0;
        for (int i = 0; i < count; i++) begin
            if (i == hold_at)
                rsp_hold_req = 1'b1;
            pick = $urandom_range(0, 99);
            k    = $urandom_range(0, 3);
            l1   = ($urandom_range(0, 9) < 7) ? IDX_W'($urandom_range(0, 3)) : IDX_W'($urandom);
            va   = make_va(l4_set[IDX_W*k +: IDX_W], IDX_W'($urandom_range(0, l3_n - 1)),
                           IDX_W'($urandom_range(0, l2_n - 1)), l1, 12'($urandom));
            if (pick < 8) begin
                send_request(OP_UNMAP, {16'($urandom), 32'($urandom)}, rand_page(),
                             {$urandom, $urandom}, r);
            end else if (pick < 45) begin
                send_request(OP_UNMAP, va, rand_page(), {$urandom, $urandom}, r);
            end else if (pick >= 92 && have_path) begin
                // wild flags only where the whole path exists, so no link gets them
                send_request(OP_MAP, {path_va[VA_W-1:21], l1, 12'($urandom)}, rand_page(),
                             {$urandom, $urandom}, r);
            end else begin
                fl = entry_flags();
                send_request(OP_MAP, va, rand_page(), fl, r);
                if (r.status == STAT_OK && fl[0]) begin
                    have_path = 1'b1;
                    path_va   = va;
                end
            end
        end
    endtask

    task automatic test_directed_walks();
        t_walk_result r;
        send_request(OP_MAP, make_va(0, 0, 0, 0, 0), '0, FL_PRESENT | FL_RW, r);
        send_request(OP_MAP, make_va(0, 0, 0, 0, 0), '1, '0, r);
        send_request(OP_MAP, '1, '1, FL_PRESENT | FL_RW | FL_NX, r);
        send_request(OP_MAP, '1, rand_page(), '1, r);
        send_request(OP_UNMAP, '1, '1, '1, r);
        // unmap where the top level is absent, then where level 2 is absent
        send_request(OP_UNMAP, make_va(5, 3, 2, 1, 12'hABC), rand_page(), '1, r);
        send_request(OP_UNMAP, make_va(0, 0, 7, 1, 0), '0, '0, r);
        // levels created without the present bit get created again
        send_request(OP_MAP, make_va(0, 0, 3, 9, 12'h123), rand_page(), FL_RW, r);
        send_request(OP_MAP, make_va(0, 0, 3, 9, 0), rand_page(), FL_PRESENT, r);
        send_request(OP_UNMAP, make_va(0, 0, 3, 9, 0), rand_page(), '1, r);
        // flag bits landing in the address field make a link outside the store
        send_request(OP_MAP, make_va(0, 2, 0, 0, 0), rand_page(),
                     FL_PRESENT | 64'h0000_0100_0000_0000, r);
        send_request(OP_MAP, make_va(0, 2, 0, 0, 0), rand_page(), FL_PRESENT, r);
        send_request(OP_UNMAP, make_va(0, 2, 0, 5, 0), rand_page(), '0, r);
        // link to a frame that is not allocated yet
        send_request(OP_MAP, make_va(1, 0, 0, 0, 0), rand_page(),
                     FL_PRESENT | 64'h3_C000, r);
        send_request(OP_MAP, make_va(1, 0, 0, 0, 0), rand_page(), FL_PRESENT, r);
    endtask

    task automatic test_random_mapping();
        gaps_on = 1'b0;
        run_random(200, {9'd1, 9'd256, 9'd511, 9'd0}, 2, 3, -1);
        gaps_on = 1'b1;
        run_random(800, {9'd1, 9'd256, 9'd511, 9'd0}, 2, 3, 300);
    endtask

    task automatic test_table_base();
        t_walk_result r;
        load_table_base(40'h00_1234_5678);
        gaps_on = 1'b0;
        run_random(60, {9'd0, 9'd101, 9'd100, 9'd100}, 1, 2, -1);
        gaps_on = 1'b1;
        run_random(140, {9'd0, 9'd101, 9'd100, 9'd100}, 1, 2, -1);
        // top base: new frame addresses wrap below the base
        load_table_base('1);
        send_request(OP_MAP, make_va(200, 0, 0, 0, 0), rand_page(), FL_PRESENT | FL_RW, r);
        send_request(OP_MAP, make_va(200, 0, 0, 0, 0), rand_page(), FL_PRESENT, r);
        send_request(OP_UNMAP, make_va(200, 0, 0, 0, 0), '0, '0, r);
        send_request(OP_MAP, make_va(0, 0, 0, 0, 0), rand_page(), FL_PRESENT, r);
        load_table_base('0);
        gaps_on = 1'b0;
        run_random(100, {9'd1, 9'd256, 9'd511, 9'd0}, 2, 3, -1);
        gaps_on = 1'b1;
        run_random(200, {9'd1, 9'd256, 9'd511, 9'd0}, 2, 3, -1);
    endtask

    task automatic test_frame_exhaustion();
        t_walk_result r;
        for (int i = 0; i < PGMAP_FRAMES && next_frame < PGMAP_FRAMES; i++)
            send_request(OP_MAP, make_va(IDX_W'(300 + i), 0, 0, 0, 0), rand_page(),
                         FL_PRESENT | FL_RW, r);
        for (int i = 0; i < 3; i++)
            send_request(OP_MAP, make_va(IDX_W'(400 + i), 1, 1, 1, 0), rand_page(),
                         FL_PRESENT, r);
        send_request(OP_MAP, make_va(0, 0, 100, 0, 0), rand_page(), FL_PRESENT, r);
        send_request(OP_MAP, make_va(0, 0, 0, 4, 0), rand_page(), FL_PRESENT | FL_RW, r);
        send_request(OP_UNMAP, make_va(0, 0, 0, 4, 0), rand_page(), '1, r);
        run_random(100, {9'd1, 9'd256, 9'd511, 9'd0}, 2, 3, -1);
    endtask

    initial begin
        foreach (shadow_tables[i])
            shadow_tables[i] = '0;
        next_frame = 1;
        table_base = '0;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_wdata      <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.opcode    <= OP_MAP;
        req_ch.virt_addr <= '0;
        req_ch.page_addr <= '0;
        req_ch.flags     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        load_table_base('0);
        test_directed_walks();
        test_random_mapping();
        test_table_base();
        test_frame_exhaustion();
        req_ch.valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (WALK_SETTLE) @(posedge i_clk);
        $display("covered %0d map/unmap items over table bases zero, mid and top, %0d frames used",
                 items_sent, next_frame);
        $display("results: %0d ok, %0d out of frames, %0d bad links, %0d tables created",
                 n_ok, n_no_frame, n_outside, n_created);
        if (!failed)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // result side: random back-pressure plus one long hold on request
    initial begin : result_drain
        int gap;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_hold_req) begin
                rsp_hold_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (RSP_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                gap = pause_cycles();
                if (gap > 0) begin
                    rsp_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_walk_result got;
        t_walk_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.status, rsp_ch.entry_value, rsp_ch.tables_created,
                   rsp_ch.invalidate_addr};
            case (got.status)
                STAT_OK:       n_ok++;
                STAT_NO_FRAME: n_no_frame++;
                STAT_OUTSIDE:  n_outside++;
                default: ;
            endcase
            n_created += got.tables_created;
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result status %0d value %h created %0d invalidate %h",
                         $time, got.status, got.entry_value, got.tables_created,
                         got.invalidate_addr);
                failed = 1'b1;
            end else begin
                want = results_due.pop_front();
                if (got !== want) begin
                    $display("%0t: expected status %0d value %h created %0d invalidate %h",
                             $time, want.status, want.entry_value, want.tables_created,
                             want.invalidate_addr);
                    $display("%0t: actual   status %0d value %h created %0d invalidate %h",
                             $time, got.status, got.entry_value, got.tables_created,
                             got.invalidate_addr);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

endmodule

`default_nettype wire
